/* src/dqpsk_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DQPSK soft demodulator package
// Field widths, operation codes and pipeline word types shared by the unit.
// ----------------------------------------------------------------------------
package dqpsk_pkg;

  // default FFT size, a power of two from 256 to 2048
  localparam int unsigned FftSizeDef = 2048;

  // port field widths
  localparam int unsigned BinW  = 11;
  localparam int unsigned PosW  = 11;
  localparam int unsigned IqW   = 16;
  localparam int unsigned SoftW = 9;

  // internal widths
  localparam int unsigned PartW  = 2 * IqW + 1;  // re/im of the product, signed
  localparam int unsigned AbsW   = 2 * IqW;      // magnitude of one part
  localparam int unsigned Mag2W  = 63;           // |r|^2, at most 2^62
  localparam int unsigned RhsW   = 79;           // part^2 * 255^2
  localparam int unsigned QW     = 8;            // soft bit magnitude, 0..255
  localparam int unsigned SqW    = 2 * QW;       // square of a soft bit magnitude
  localparam int unsigned ProdLoW = SqW + 32;
  localparam int unsigned ProdHiW = SqW + Mag2W - 32;

  // operation codes of the func field
  localparam logic FuncStore  = 1'b0;
  localparam logic FuncDecode = 1'b1;

  // a soft bit never takes the most negative code
  localparam logic [SoftW-1:0] SoftNegLimit = {1'b1, {(SoftW-1){1'b0}}};

  // word carried between the steps of the magnitude search
  typedef struct packed {
    logic [PosW-1:0]  pos;
    logic             neg_r;   // real part positive: soft bit negative
    logic             neg_i;
    logic             zero;    // |r| is zero
    logic [Mag2W-1:0] mag2;
    logic [RhsW-1:0]  rhs_r;
    logic [RhsW-1:0]  rhs_i;
    logic [QW-1:0]    q_r;
    logic [QW-1:0]    q_i;
    logic [SqW-1:0]   qsq_r;
    logic [SqW-1:0]   qsq_i;
  } srch_t;

  // partial products of one search step
  typedef struct packed {
    srch_t              s;
    logic [SqW-1:0]     c2_r;
    logic [SqW-1:0]     c2_i;
    logic [ProdLoW-1:0] plo_r;
    logic [ProdHiW-1:0] phi_r;
    logic [ProdLoW-1:0] plo_i;
    logic [ProdHiW-1:0] phi_i;
  } prod_t;

endpackage

/* src/dqpsk_soft_demodulator_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DQPSK differential soft demodulator
// Per-bin phase reference store and exact soft bit pipeline.
// ----------------------------------------------------------------------------
// One carrier word is taken every clock cycle unless stalled. Each decode word
// gives one result and a reference word none. The rate is set by the phase
// reference memory (FFT_SIZE x 32 bits), which is read and written once per
// word at the same address, read before write, so a bin used in back-to-back
// words always sees the latest reference. The soft bits come from an
// eight-step search over the magnitude, two pipeline stages per bit. FFT_SIZE
// must be a power of two; the bin number is taken modulo it. A decode of a bin
// whose reference was never stored gives undefined soft bits.
module dqpsk_soft_demodulator_unit #(
  parameter int unsigned FFT_SIZE = dqpsk_pkg::FftSizeDef
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic                               func_i,
  input  logic        [dqpsk_pkg::BinW-1:0]  bin_index_i,
  input  logic        [dqpsk_pkg::PosW-1:0]  carrier_pos_i,
  input  logic signed [dqpsk_pkg::IqW-1:0]   bin_re_i,
  input  logic signed [dqpsk_pkg::IqW-1:0]   bin_im_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic        [dqpsk_pkg::PosW-1:0]  out_pos_o,
  output logic signed [dqpsk_pkg::SoftW-1:0] soft_real_o,
  output logic signed [dqpsk_pkg::SoftW-1:0] soft_imag_o
);
  import dqpsk_pkg::*;

  localparam int unsigned AW = $clog2(FFT_SIZE);

  // stage enables, from the output back to the input
  logic out_en, e1, e2, e3, e4, e5;
  logic se [9];
  logic pe [8];

  // phase reference memory
  logic [2*IqW-1:0] ref_mem [FFT_SIZE];
  logic [AW-1:0]    ref_addr;
  logic             accept;

  // stage registers
  logic                    v1_q, v2_q, v3_q, v4_q, v5_q;
  logic [PosW-1:0]         pos1_q, pos2_q, pos3_q, pos4_q, pos5_q;
  logic signed [IqW-1:0]   xr1_q, xi1_q;
  logic [2*IqW-1:0]        ref1_q;
  logic signed [2*IqW-1:0] p_rr2_q, p_ii2_q, p_ir2_q, p_ri2_q;
  logic signed [PartW-1:0] re3_q, im3_q;
  logic [AbsW-1:0]         a4_q, b4_q;
  logic                    nr4_q, ni4_q, nr5_q, ni5_q;
  logic [Mag2W-1:0]        a2_5_q, b2_5_q;
  logic signed [IqW-1:0]   ref_re, ref_im;
  logic [2*AbsW-1:0]       a_sq, b_sq;

  srch_t srch_q [9];
  logic  sv_q   [9];
  prod_t prod_q [8];
  logic  pv_q   [8];

  logic                    out_valid_q;
  logic [PosW-1:0]         out_pos_q;
  logic signed [SoftW-1:0] soft_r_q, soft_i_q;

  // ready chain: a stage loads when it is empty or its word moves on
  assign out_en     = !out_valid_q || out_ready_i;
  assign se[0]      = !sv_q[0] || out_en;
  assign e5         = !v5_q || se[8];
  assign e4         = !v4_q || e5;
  assign e3         = !v3_q || e4;
  assign e2         = !v2_q || e3;
  assign e1         = !v1_q || e2;
  assign in_ready_o = e1;
  assign accept     = in_valid_i && e1;
  assign ref_addr   = bin_index_i[AW-1:0];

  // store the new reference; read the old one for the same word
  always_ff @(posedge clk_i) begin
    if (accept) begin
      ref_mem[ref_addr] <= {bin_im_i, bin_re_i};
    end
    if (e1) begin
      ref1_q <= ref_mem[ref_addr];
    end
  end

  // valid bits of the front stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      if (e1) v1_q <= in_valid_i && (func_i == FuncDecode);
      if (e2) v2_q <= v1_q;
      if (e3) v3_q <= v2_q;
      if (e4) v4_q <= v3_q;
      if (e5) v5_q <= v4_q;
    end
  end

  assign ref_re = ref1_q[IqW-1:0];
  assign ref_im = ref1_q[2*IqW-1:IqW];
  assign a_sq   = a4_q * a4_q;
  assign b_sq   = b4_q * b4_q;

  // front datapath: product with the conjugate, magnitudes, squares
  always_ff @(posedge clk_i) begin
    if (e1) begin
      pos1_q <= carrier_pos_i;
      xr1_q  <= bin_re_i;
      xi1_q  <= bin_im_i;
    end
    if (e2) begin
      pos2_q  <= pos1_q;
      p_rr2_q <= xr1_q * ref_re;
      p_ii2_q <= xi1_q * ref_im;
      p_ir2_q <= xi1_q * ref_re;
      p_ri2_q <= xr1_q * ref_im;
    end
    if (e3) begin
      pos3_q <= pos2_q;
      re3_q  <= PartW'(p_rr2_q) + PartW'(p_ii2_q);
      im3_q  <= PartW'(p_ir2_q) - PartW'(p_ri2_q);
    end
    if (e4) begin
      pos4_q <= pos3_q;
      a4_q   <= re3_q[PartW-1] ? AbsW'(-re3_q) : re3_q[AbsW-1:0];
      b4_q   <= im3_q[PartW-1] ? AbsW'(-im3_q) : im3_q[AbsW-1:0];
      nr4_q  <= !re3_q[PartW-1];
      ni4_q  <= !im3_q[PartW-1];
    end
    if (e5) begin
      pos5_q <= pos4_q;
      a2_5_q <= a_sq[Mag2W-1:0];
      b2_5_q <= b_sq[Mag2W-1:0];
      nr5_q  <= nr4_q;
      ni5_q  <= ni4_q;
    end
  end

  // search entry: |r|^2 and part^2 * 255^2 (255^2 = 2^16 - 2^9 + 1)
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sv_q[8] <= 1'b0;
    end else if (se[8]) begin
      sv_q[8] <= v5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (se[8]) begin
      srch_q[8].pos   <= pos5_q;
      srch_q[8].neg_r <= nr5_q;
      srch_q[8].neg_i <= ni5_q;
      srch_q[8].zero  <= (a2_5_q == '0) && (b2_5_q == '0);
      srch_q[8].mag2  <= a2_5_q + b2_5_q;
      srch_q[8].rhs_r <= (RhsW'(a2_5_q) << 16) - (RhsW'(a2_5_q) << 9) + RhsW'(a2_5_q);
      srch_q[8].rhs_i <= (RhsW'(b2_5_q) << 16) - (RhsW'(b2_5_q) << 9) + RhsW'(b2_5_q);
      srch_q[8].q_r   <= '0;
      srch_q[8].q_i   <= '0;
      srch_q[8].qsq_r <= '0;
      srch_q[8].qsq_i <= '0;
    end
  end

  // one soft bit per step, most significant first
  for (genvar k = 0; k < QW; k++) begin : g_step
    logic [SqW-1:0] c2_r, c2_i;
    logic [RhsW-1:0] lhs_r, lhs_i;
    logic            hit_r, hit_i;
    srch_t           srch_d;

    assign pe[k]   = !pv_q[k] || se[k];
    assign se[k+1] = !sv_q[k+1] || pe[k];

    // square of the candidate with this bit set
    assign c2_r = srch_q[k+1].qsq_r + ({{QW{1'b0}}, srch_q[k+1].q_r} << (k + 1))
                + (SqW'(1) << (2 * k));
    assign c2_i = srch_q[k+1].qsq_i + ({{QW{1'b0}}, srch_q[k+1].q_i} << (k + 1))
                + (SqW'(1) << (2 * k));

    // keep the candidate where candidate^2 * |r|^2 stays within part^2 * 255^2
    assign lhs_r = (RhsW'(prod_q[k].phi_r) << 32) + RhsW'(prod_q[k].plo_r);
    assign lhs_i = (RhsW'(prod_q[k].phi_i) << 32) + RhsW'(prod_q[k].plo_i);
    assign hit_r = lhs_r <= prod_q[k].s.rhs_r;
    assign hit_i = lhs_i <= prod_q[k].s.rhs_i;

    // fold the decided bit into the word
    always_comb begin
      srch_d       = prod_q[k].s;
      srch_d.q_r   = prod_q[k].s.q_r | (QW'(hit_r) << k);
      srch_d.q_i   = prod_q[k].s.q_i | (QW'(hit_i) << k);
      srch_d.qsq_r = hit_r ? prod_q[k].c2_r : prod_q[k].s.qsq_r;
      srch_d.qsq_i = hit_i ? prod_q[k].c2_i : prod_q[k].s.qsq_i;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        pv_q[k] <= 1'b0;
        sv_q[k] <= 1'b0;
      end else begin
        if (pe[k]) pv_q[k] <= sv_q[k+1];
        if (se[k]) sv_q[k] <= pv_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (pe[k]) begin
        prod_q[k].s     <= srch_q[k+1];
        prod_q[k].c2_r  <= c2_r;
        prod_q[k].c2_i  <= c2_i;
        prod_q[k].plo_r <= c2_r * srch_q[k+1].mag2[31:0];
        prod_q[k].phi_r <= c2_r * srch_q[k+1].mag2[Mag2W-1:32];
        prod_q[k].plo_i <= c2_i * srch_q[k+1].mag2[31:0];
        prod_q[k].phi_i <= c2_i * srch_q[k+1].mag2[Mag2W-1:32];
      end
      if (se[k]) begin
        srch_q[k] <= srch_d;
      end
    end
  end

  // output register: apply the sign, zero magnitude gives zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_en) begin
      out_valid_q <= sv_q[0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_en) begin
      out_pos_q <= srch_q[0].pos;
      if (srch_q[0].zero) begin
        soft_r_q <= '0;
        soft_i_q <= '0;
      end else begin
        soft_r_q <= srch_q[0].neg_r ? -SoftW'(srch_q[0].q_r) : SoftW'(srch_q[0].q_r);
        soft_i_q <= srch_q[0].neg_i ? -SoftW'(srch_q[0].q_i) : SoftW'(srch_q[0].q_i);
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_pos_o   = out_pos_q;
  assign soft_real_o = soft_r_q;
  assign soft_imag_o = soft_i_q;

  // reference words never enter the pipeline
  a_store_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && (func_i == FuncStore)) |=> !v1_q)
    else $error("reference word entered the decode pipeline");

  // decode words always enter the pipeline
  a_decode_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && (func_i == FuncDecode)) |=> v1_q)
    else $error("decode word lost at the input");

  // zero magnitude only when both part terms vanish
  a_zero_rhs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sv_q[8] && srch_q[8].zero) |-> ((srch_q[8].rhs_r == '0) && (srch_q[8].rhs_i == '0)))
    else $error("zero magnitude with a non-zero part");

  // soft bits stay within -255..255
  a_soft_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((soft_real_o != SoftNegLimit) && (soft_imag_o != SoftNegLimit)))
    else $error("soft bit out of range");

endmodule
